/* sv/ptw_pkg.sv */
// ----------------------------------------------------------------------------
// ptw_pkg
// Shared types, codes and helper functions for the translation table walker.
// ----------------------------------------------------------------------------
package ptw_pkg;

    // Address and field widths
    localparam int ADDR_BITS  = 48;
    localparam int DESC_BITS  = 64;
    localparam int GRAN_BITS  = 5;
    localparam int LVLS_BITS  = 3;
    localparam int LEVEL_BITS = 2;
    localparam int KIND_BITS  = 2;
    localparam int IDX_BITS   = 13;   // widest level index (64K granule)
    localparam int SHIFT_BITS = 6;    // holds shift amounts up to 55

    // Stream payload widths
    localparam int IN_DATA_BITS  = 2 * ADDR_BITS + DESC_BITS;
    localparam int OUT_FIELDS    = 2 * ADDR_BITS + LEVEL_BITS;
    localparam int OUT_DATA_BITS = ((OUT_FIELDS + 7) / 8) * 8;

    // Configuration port
    localparam int APB_ADDR_BITS = 3;
    localparam int APB_DATA_BITS = 32;
    localparam logic REG_GRANULE = 1'b0;
    localparam logic REG_LEVELS  = 1'b1;

    // Register reset values
    localparam logic [GRAN_BITS-1:0] GRANULE_RESET = 5'd12;
    localparam logic [LVLS_BITS-1:0] LEVELS_RESET  = 3'd4;

    // Input operation codes
    localparam logic OP_START = 1'b0;
    localparam logic OP_RESP  = 1'b1;

    // Result kinds
    localparam logic [KIND_BITS-1:0] KIND_REQ   = 2'd0;
    localparam logic [KIND_BITS-1:0] KIND_DONE  = 2'd1;
    localparam logic [KIND_BITS-1:0] KIND_FAULT = 2'd2;

    // Descriptor type codes and the last level
    localparam logic [1:0] DESC_TABLE = 2'b11;
    localparam logic [1:0] DESC_BLOCK = 2'b01;
    localparam logic [LEVEL_BITS-1:0] LAST_LEVEL = 2'd3;

    localparam logic [ADDR_BITS-1:0] ADDR_ONES = {ADDR_BITS{1'b1}};

    // Walk state carried from one transaction to the next
    typedef struct packed {
        logic                  busy;
        logic [LEVEL_BITS-1:0] level;
        logic [ADDR_BITS-1:0]  vaddr;
        logic [ADDR_BITS-1:0]  entry;
    } walk_state_t;

    // One input transaction
    typedef struct packed {
        logic                 op;
        logic [ADDR_BITS-1:0] table_base;
        logic [ADDR_BITS-1:0] virt_addr;
        logic [DESC_BITS-1:0] descriptor;
    } walk_item_t;

    // One result transaction
    typedef struct packed {
        logic [KIND_BITS-1:0]  kind;
        logic [ADDR_BITS-1:0]  entry_addr;
        logic [LEVEL_BITS-1:0] final_level;
        logic [ADDR_BITS-1:0]  frame_addr;
    } walk_result_t;

    // Unsupported granule encodings fall back to the 4K granule.
    function automatic logic [GRAN_BITS-1:0] eff_granule(input logic [GRAN_BITS-1:0] raw);
        logic [GRAN_BITS-1:0] g;
        g = GRANULE_RESET;
        if (raw == 5'd14 || raw == 5'd16)
        begin
            g = raw;
        end
        return g;
    endfunction

    // Level count is clamped into one to four.
    function automatic logic [LVLS_BITS-1:0] eff_levels(input logic [LVLS_BITS-1:0] raw);
        logic [LVLS_BITS-1:0] n;
        n = raw;
        if (raw == 3'd0)
        begin
            n = 3'd1;
        end
        else if (raw > 3'd4)
        begin
            n = 3'd4;
        end
        return n;
    endfunction

    // Address bits from lo up to the top; zero once lo reaches the width.
    function automatic logic [ADDR_BITS-1:0] high_mask(input logic [SHIFT_BITS-1:0] lo);
        return ADDR_ONES << lo;
    endfunction

endpackage

/* sv/ptw_core.sv */
// ----------------------------------------------------------------------------
// ptw_core
// Single-pass decode of one walker transaction: computes the result and the
// next walk state from the current state, the configuration and the item.
// ----------------------------------------------------------------------------
module ptw_core
(
    input  logic [ptw_pkg::GRAN_BITS-1:0] granule_shift,
    input  logic [ptw_pkg::LVLS_BITS-1:0] table_levels,
    input  ptw_pkg::walk_state_t          state,
    input  ptw_pkg::walk_item_t           item,
    output ptw_pkg::walk_state_t          state_next,
    output ptw_pkg::walk_result_t         result
);
    import ptw_pkg::*;

    logic [GRAN_BITS-1:0]  gran;
    logic [3:0]            idx_bits;
    logic [LVLS_BITS-1:0]  levels;
    logic [LEVEL_BITS-1:0] start_level;
    logic [1:0]            desc_type;
    logic                  is_start;
    logic                  next_table;

    logic [ADDR_BITS-1:0]  req_base;
    logic [ADDR_BITS-1:0]  req_vaddr;
    logic [LEVEL_BITS-1:0] req_level;
    logic [2:0]            levels_left;
    logic [SHIFT_BITS-1:0] idx_shift;
    logic [IDX_BITS-1:0]   idx_mask;
    logic [IDX_BITS-1:0]   idx;
    logic [ADDR_BITS-1:0]  req_entry;

    logic [SHIFT_BITS-1:0] frame_lsb;
    logic [ADDR_BITS-1:0]  frame;

    // Effective configuration
    assign gran        = eff_granule(granule_shift);
    assign idx_bits    = 4'(gran - 5'd3);
    assign levels      = eff_levels(table_levels);
    assign start_level = LEVEL_BITS'(3'd4 - levels);

    assign desc_type  = item.descriptor[1:0];
    assign is_start   = (item.op == OP_START);
    assign next_table = (desc_type == DESC_TABLE) && (state.level != LAST_LEVEL);

    // Operands of the descriptor read: a new walk or the next table level
    always_comb
    begin
        if (is_start)
        begin
            req_base  = item.table_base;
            req_vaddr = item.virt_addr;
            req_level = start_level;
        end
        else
        begin
            req_base  = item.descriptor[ADDR_BITS-1:0] & high_mask(SHIFT_BITS'(gran));
            req_vaddr = state.vaddr;
            req_level = state.level + 2'd1;
        end
    end

    // Descriptor address: base plus eight times the level index
    assign levels_left = 3'd4 - {1'b0, req_level};
    assign idx_shift   = ({2'b00, idx_bits} * {3'b000, levels_left}) + 6'd3;
    assign idx_mask    = ~({IDX_BITS{1'b1}} << idx_bits);
    assign idx         = IDX_BITS'(req_vaddr >> idx_shift) & idx_mask;
    assign req_entry   = req_base + ADDR_BITS'({idx, 3'b000});

    // Output frame of a finished walk: bits above the block size
    assign frame_lsb = ({2'b00, idx_bits} * {4'b0000, LAST_LEVEL - state.level})
                       + SHIFT_BITS'(gran);
    assign frame     = item.descriptor[ADDR_BITS-1:0] & high_mask(frame_lsb);

    // Result and state update
    always_comb
    begin
        state_next         = state;
        result.kind        = KIND_FAULT;
        result.entry_addr  = '0;
        result.final_level = '0;
        result.frame_addr  = '0;

        if (is_start)
        begin
            state_next.vaddr = item.virt_addr;
        end

        if (is_start || (state.busy && next_table))
        begin
            // Issue a read, or fault on a zero descriptor address
            result.final_level = req_level;
            if (req_entry == '0)
            begin
                state_next.busy = 1'b0;
            end
            else
            begin
                state_next.busy   = 1'b1;
                state_next.level  = req_level;
                state_next.entry  = req_entry;
                result.kind       = KIND_REQ;
                result.entry_addr = req_entry;
            end
        end
        else if (state.busy)
        begin
            // Walk ends: block or last-level page, or an invalid descriptor
            state_next.busy    = 1'b0;
            result.entry_addr  = state.entry;
            result.final_level = state.level;
            if (desc_type == DESC_TABLE || desc_type == DESC_BLOCK)
            begin
                result.kind       = KIND_DONE;
                result.frame_addr = frame;
            end
        end
    end

endmodule

/* sv/page_table_walker.sv */
// ----------------------------------------------------------------------------
// page_table_walker
// Translation table walker with configurable granule and level count.
// ----------------------------------------------------------------------------
// An accepted transaction is held in the input register, its result in the
// result register. Throughput: one transaction per cycle unless the result
// stream stalls; decode between the two registers reads and writes the walk state.
// Reset: asynchronous, active low; the walker goes idle, granule_shift reads
// 12 and table_levels reads 4.
module page_table_walker
(
    input  logic                                clk,
    input  logic                                rst_n,

    // Input stream
    input  logic                                s_tvalid,
    output logic                                s_tready,
    // [47:0] table_base, [95:48] virt_addr, [159:96] descriptor
    input  logic [ptw_pkg::IN_DATA_BITS-1:0]    s_tdata,
    // [0] op
    input  logic                                s_tuser,

    // Result stream
    output logic                                m_tvalid,
    input  logic                                m_tready,
    // [47:0] entry_addr, [49:48] final_level, [97:50] frame_addr, zero pad
    output logic [ptw_pkg::OUT_DATA_BITS-1:0]   m_tdata,
    // [1:0] kind
    output logic [ptw_pkg::KIND_BITS-1:0]       m_tuser,

    // Configuration port
    input  logic                                psel,
    input  logic                                penable,
    input  logic                                pwrite,
    input  logic [ptw_pkg::APB_ADDR_BITS-1:0]   paddr,
    input  logic [ptw_pkg::APB_DATA_BITS-1:0]   pwdata,
    output logic [ptw_pkg::APB_DATA_BITS-1:0]   prdata,
    output logic                                pready
);
    import ptw_pkg::*;

    logic [GRAN_BITS-1:0] granule_reg;
    logic [LVLS_BITS-1:0] levels_reg;
    logic                 cfg_write;
    logic                 reg_sel;

    logic                 in_valid_reg;
    walk_item_t           in_item_reg;
    logic                 out_valid_reg;
    walk_result_t         out_result_reg;
    walk_state_t          state_reg;
    walk_state_t          state_next;
    walk_result_t         result_next;
    logic                 advance;
    logic                 in_take;

    // Configuration registers
    assign pready    = 1'b1;
    assign reg_sel   = paddr[2];
    assign cfg_write = psel && penable && pwrite && pready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            granule_reg <= GRANULE_RESET;
            levels_reg  <= LEVELS_RESET;
        end
        else if (cfg_write)
        begin
            if (reg_sel == REG_GRANULE)
            begin
                granule_reg <= pwdata[GRAN_BITS-1:0];
            end
            else
            begin
                levels_reg <= pwdata[LVLS_BITS-1:0];
            end
        end
    end

    always_comb
    begin
        case (reg_sel)
            REG_GRANULE: prdata = APB_DATA_BITS'(granule_reg);
            REG_LEVELS:  prdata = APB_DATA_BITS'(levels_reg);
            default:     prdata = '0;
        endcase
    end

    // Handshake: the input register moves on whenever the result register
    // is empty or its transaction is being taken.
    assign advance  = !out_valid_reg || m_tready;
    assign s_tready = !in_valid_reg || advance;
    assign in_take  = s_tvalid && s_tready;

    // Input register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg <= 1'b0;
        end
        else if (s_tready)
        begin
            in_valid_reg <= s_tvalid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_take)
        begin
            in_item_reg.op         <= s_tuser;
            in_item_reg.table_base <= s_tdata[ADDR_BITS-1:0];
            in_item_reg.virt_addr  <= s_tdata[2*ADDR_BITS-1:ADDR_BITS];
            in_item_reg.descriptor <= s_tdata[IN_DATA_BITS-1:2*ADDR_BITS];
        end
    end

    // Decode of the held transaction
    ptw_core u_core
    (
        .granule_shift (granule_reg),
        .table_levels  (levels_reg),
        .state         (state_reg),
        .item          (in_item_reg),
        .state_next    (state_next),
        .result        (result_next)
    );

    // Walk state and result register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= '0;
            out_valid_reg <= 1'b0;
        end
        else if (advance)
        begin
            out_valid_reg <= in_valid_reg;
            if (in_valid_reg)
            begin
                state_reg <= state_next;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (advance && in_valid_reg)
        begin
            out_result_reg <= result_next;
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tuser  = out_result_reg.kind;
    assign m_tdata  = OUT_DATA_BITS'({out_result_reg.frame_addr,
                                      out_result_reg.final_level,
                                      out_result_reg.entry_addr});

`ifndef ASSERT_OFF
    // A new result leaves the walker busy exactly when it is a read request.
    assert property (@(posedge clk) disable iff (!rst_n)
        (advance && in_valid_reg) |=> ((m_tuser == KIND_REQ) == state_reg.busy))
        else $error("walk busy flag disagrees with the last result kind");

    // Only a finished walk carries a frame address.
    assert property (@(posedge clk) disable iff (!rst_n)
        (m_tvalid && m_tuser != KIND_DONE) |-> (out_result_reg.frame_addr == '0))
        else $error("frame address set on a result that is not done");

    // A read request never targets address zero.
    assert property (@(posedge clk) disable iff (!rst_n)
        (m_tvalid && m_tuser == KIND_REQ) |-> (out_result_reg.entry_addr != '0))
        else $error("read request at address zero");

    // The result kind is always one of request, done or fault.
    assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid |-> (m_tuser == KIND_REQ || m_tuser == KIND_DONE ||
                      m_tuser == KIND_FAULT))
        else $error("undefined result kind");
`endif

endmodule
